// File: rtl/lfs_pkg.sv
// Package for the line follower steering block: bin and state codes,
// the next-state and drive tables, and the queue entry type.
// No dependencies.
package lfs_pkg;

    // Position bins.
    localparam logic [2:0] BIN_FAR_LEFT  = 3'd0;  // below -30000
    localparam logic [2:0] BIN_LEFT      = 3'd1;  // below -15000
    localparam logic [2:0] BIN_MID       = 3'd2;  // below 15000, or unknown high value
    localparam logic [2:0] BIN_RIGHT     = 3'd3;  // up to 30000
    localparam logic [2:0] BIN_FAR_RIGHT = 3'd4;  // up to 33400
    localparam logic [2:0] BIN_LOST      = 3'd5;  // line lost marker

    // Steering states.
    localparam logic [2:0] ST_CENTER    = 3'd0;
    localparam logic [2:0] ST_LOST_CTR  = 3'd1;
    localparam logic [2:0] ST_CTR_RIGHT = 3'd2;
    localparam logic [2:0] ST_CTR_LEFT  = 3'd3;
    localparam logic [2:0] ST_RIGHT     = 3'd4;
    localparam logic [2:0] ST_LOST_RGT  = 3'd5;
    localparam logic [2:0] ST_LEFT      = 3'd6;
    localparam logic [2:0] ST_LOST_LFT  = 3'd7;

    // Bin thresholds and the lost marker, at the input width.
    localparam logic signed [20:0] POS_FAR_LEFT  = -21'sd30000;
    localparam logic signed [20:0] POS_LEFT      = -21'sd15000;
    localparam logic signed [20:0] POS_RIGHT     = 21'sd15000;
    localparam logic signed [20:0] POS_FAR_RIGHT = 21'sd30000;
    localparam logic signed [20:0] POS_EDGE      = 21'sd33400;
    localparam logic signed [20:0] POS_LOST      = 21'sd1000000;

    // Offset subtracted before the proportional correction, 22 bits signed.
    localparam logic signed [21:0] CORR_OFFSET = 22'sd15000;

    // Division by five through a reciprocal: floor(a / 5) equals
    // (a * DIV5_MUL) >> DIV5_SHIFT for every a below 2**22.
    localparam int unsigned   DIV5_SHIFT = 24;
    localparam logic [21:0]   DIV5_MUL   = 22'd3355444;

    typedef logic [2:0] t_bin;
    typedef logic [2:0] t_state;

    // Next state by [state][bin]. Bin codes six and seven never occur and
    // repeat the middle-bin entry.
    localparam t_state NEXT_TAB [8][8] = '{
        '{ST_CTR_RIGHT, ST_CTR_RIGHT, ST_CENTER,    ST_CTR_LEFT,
          ST_CTR_LEFT,  ST_LOST_CTR,  ST_CENTER,    ST_CENTER},
        '{ST_CTR_RIGHT, ST_CENTER,    ST_CENTER,    ST_CENTER,
          ST_CTR_LEFT,  ST_LOST_CTR,  ST_CENTER,    ST_CENTER},
        '{ST_RIGHT,     ST_CTR_RIGHT, ST_CENTER,    ST_CENTER,
          ST_CTR_LEFT,  ST_LOST_RGT,  ST_CENTER,    ST_CENTER},
        '{ST_CTR_RIGHT, ST_CENTER,    ST_CENTER,    ST_CTR_LEFT,
          ST_LEFT,      ST_LOST_LFT,  ST_CENTER,    ST_CENTER},
        '{ST_RIGHT,     ST_CTR_RIGHT, ST_CTR_RIGHT, ST_CTR_RIGHT,
          ST_CENTER,    ST_LOST_RGT,  ST_CTR_RIGHT, ST_CTR_RIGHT},
        '{ST_RIGHT,     ST_CTR_RIGHT, ST_CTR_RIGHT, ST_CTR_RIGHT,
          ST_CENTER,    ST_LOST_RGT,  ST_CTR_RIGHT, ST_CTR_RIGHT},
        '{ST_CENTER,    ST_CTR_LEFT,  ST_CTR_LEFT,  ST_CTR_LEFT,
          ST_LEFT,      ST_LOST_LFT,  ST_CTR_LEFT,  ST_CTR_LEFT},
        '{ST_CENTER,    ST_CTR_LEFT,  ST_CTR_LEFT,  ST_CTR_LEFT,
          ST_LEFT,      ST_LOST_LFT,  ST_CTR_LEFT,  ST_CTR_LEFT}
    };

    // Base drive values by state.
    localparam logic signed [15:0] DRIVE_FIRST [8] = '{
        16'sd8000, 16'sd8000, 16'sd8000, 16'sd8000,
        16'sd10000, 16'sd8000, -16'sd2000, -16'sd6000
    };
    localparam logic signed [15:0] DRIVE_SECOND [8] = '{
        16'sd8000, 16'sd8000, 16'sd8000, 16'sd8000,
        -16'sd2000, -16'sd6000, 16'sd10000, 16'sd8000
    };

    // One classified sample: its bin and both corrections as sign and
    // magnitude, the magnitude already divided by five and cut to 16 bits.
    typedef struct packed {
        t_bin        bin;
        logic        neg_right;
        logic [15:0] mag_right;
        logic        neg_left;
        logic [15:0] mag_left;
    } t_entry;

endpackage

// File: rtl/lfs_front.sv
// Front end of the steering block: registers each position, bins it and
// divides both correction terms by five. Depends on lfs_pkg.
module lfs_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_vld,
    output logic                 o_rdy,
    input  logic signed [20:0]   i_pos,
    output logic                 o_vld,
    input  logic                 i_rdy,
    output lfs_pkg::t_entry      o_entry
);
    import lfs_pkg::*;

    logic               r_vld;
    t_bin               r_bin;
    logic               r_neg_right;
    logic               r_neg_left;
    logic [20:0]        r_mag_right;
    logic [20:0]        r_mag_left;

    t_bin               n_bin;
    logic signed [21:0] diff_right;
    logic signed [21:0] diff_left;
    logic [21:0]        abs_right;
    logic [21:0]        abs_left;
    logic [42:0]        prod_right;
    logic [42:0]        prod_left;

    assign o_rdy = !r_vld || i_rdy;

    always_comb begin
        if (i_pos < POS_FAR_LEFT) begin
            n_bin = BIN_FAR_LEFT;
        end else if (i_pos < POS_LEFT) begin
            n_bin = BIN_LEFT;
        end else if (i_pos < POS_RIGHT) begin
            n_bin = BIN_MID;
        end else if (i_pos <= POS_FAR_RIGHT) begin
            n_bin = BIN_RIGHT;
        end else if (i_pos <= POS_EDGE) begin
            n_bin = BIN_FAR_RIGHT;
        end else if (i_pos == POS_LOST) begin
            n_bin = BIN_LOST;
        end else begin
            n_bin = BIN_MID;
        end
    end

    // Both differences stay within 21 bits of magnitude.
    assign diff_right = {i_pos[20], i_pos} - CORR_OFFSET;
    assign diff_left  = {i_pos[20], i_pos} + CORR_OFFSET;
    assign abs_right  = diff_right[21] ? 22'(-diff_right) : 22'(diff_right);
    assign abs_left   = diff_left[21]  ? 22'(-diff_left)  : 22'(diff_left);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_rdy) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_rdy && i_vld) begin
            r_bin       <= n_bin;
            r_neg_right <= diff_right[21];
            r_neg_left  <= diff_left[21];
            r_mag_right <= abs_right[20:0];
            r_mag_left  <= abs_left[20:0];
        end
    end

    // Divide the registered magnitudes by five.
    assign prod_right = 43'(r_mag_right) * 43'(DIV5_MUL);
    assign prod_left  = 43'(r_mag_left)  * 43'(DIV5_MUL);

    assign o_vld               = r_vld;
    assign o_entry.bin         = r_bin;
    assign o_entry.neg_right   = r_neg_right;
    assign o_entry.mag_right   = prod_right[DIV5_SHIFT +: 16];
    assign o_entry.neg_left    = r_neg_left;
    assign o_entry.mag_left    = prod_left[DIV5_SHIFT +: 16];

endmodule

// File: rtl/lfs_queue.sv
// Short first-in first-out queue of classified samples between the front
// end and the back end. Depends on lfs_pkg.
module lfs_queue #(
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push_vld,
    output logic             o_push_rdy,
    input  lfs_pkg::t_entry  i_push_data,
    output logic             o_pop_vld,
    input  logic             i_pop_rdy,
    output lfs_pkg::t_entry  o_pop_data
);
    import lfs_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_entry         r_mem [DEPTH];
    logic [AW-1:0]  r_wr_ptr;
    logic [AW-1:0]  r_rd_ptr;
    logic [CW-1:0]  r_count;

    logic           push;
    logic           pop;

    assign o_push_rdy = r_count != CW'(DEPTH);
    assign o_pop_vld  = r_count != '0;
    assign push       = i_push_vld && o_push_rdy;
    assign pop        = o_pop_vld && i_pop_rdy;
    assign o_pop_data = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_count_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("queue fill count beyond depth");

    a_count_step : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == $past(r_count)) || (r_count == $past(r_count) + 1'b1) ||
        (r_count == $past(r_count) - 1'b1))
        else $error("queue fill count jumped");
`endif

endmodule

// File: rtl/lfs_back.sv
// Back end of the steering block: steps the steering state, looks up the
// drive pair, applies the correction and holds the output word.
// Depends on lfs_pkg.
module lfs_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_vld,
    output logic                 o_rdy,
    input  lfs_pkg::t_entry      i_entry,
    output logic                 o_vld,
    input  logic                 i_rdy,
    output logic signed [15:0]   o_first,
    output logic signed [15:0]   o_second,
    output lfs_pkg::t_state      o_state
);
    import lfs_pkg::*;

    t_state             r_mode;
    logic               r_vld;
    logic signed [15:0] r_first;
    logic signed [15:0] r_second;
    t_state             r_state;

    t_state             n_state;
    logic signed [15:0] n_first;
    logic signed [15:0] n_second;
    logic signed [15:0] corr_right;
    logic signed [15:0] corr_left;

    assign o_rdy = !r_vld || i_rdy;

    assign corr_right = i_entry.neg_right ? 16'(-i_entry.mag_right) : i_entry.mag_right;
    assign corr_left  = i_entry.neg_left  ? 16'(-i_entry.mag_left)  : i_entry.mag_left;

    always_comb begin
        n_state  = NEXT_TAB[r_mode][i_entry.bin];
        n_first  = DRIVE_FIRST[n_state];
        n_second = DRIVE_SECOND[n_state];
        if (n_state == ST_CTR_RIGHT) begin
            n_second = n_second + corr_right;
        end else if (n_state == ST_CTR_LEFT) begin
            n_first = n_first - corr_left;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= ST_CENTER;
            r_vld  <= 1'b0;
        end else if (o_rdy) begin
            r_vld <= i_vld;
            if (i_vld) begin
                r_mode <= n_state;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_rdy && i_vld) begin
            r_first  <= n_first;
            r_second <= n_second;
            r_state  <= n_state;
        end
    end

    assign o_vld    = r_vld;
    assign o_first  = r_first;
    assign o_second = r_second;
    assign o_state  = r_state;

`ifndef NO_ASSERTIONS
    a_state_shown : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld |-> (r_state == r_mode))
        else $error("shown state differs from steering state");

    a_reset_center : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(i_rst_n) |-> (r_mode == ST_CENTER && !r_vld))
        else $error("steering state not centered after reset");

    a_center_drive : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld && (r_state == ST_CENTER || r_state == ST_LOST_CTR)) |->
        (r_first == DRIVE_FIRST[ST_CENTER] && r_second == DRIVE_SECOND[ST_CENTER]))
        else $error("center drive values corrupted");
`endif

endmodule

// File: rtl/line_follower_steering_fsm.sv
// Top level of the line follower steering block: front end, queue and
// back end. Depends on lfs_pkg, lfs_front, lfs_queue and lfs_back.
//
//  Channel   Dir  Ports                       Word contents (lowest bit up)
//  --------  ---  --------------------------  -------------------------------------
//  sample    in   i_s_tvalid/o_s_tready       position[20:0], zero pad to 24 bits
//  drive     out  o_m_tvalid/i_m_tready       wheel_first[15:0], wheel_second[31:16],
//                                             steer_state[34:32], zero pad to 40 bits
//
// One word is accepted every cycle as long as the drive side keeps taking
// results; each sample yields exactly one drive word. An accepted sample
// is binned and registered in the front end, pushed into the queue with its
// divided corrections, and then popped into the output register of the back
// end. The steering state updates in the back end only, one sample per cycle
// while samples arrive and the drive side takes results.
// Reset is synchronous and active low; it empties the pipeline and the queue
// and puts the steering state in center. When the drive side stalls, the
// queue absorbs up to QUEUE_DEPTH words before the front end and then the
// sample side stall in turn.
module line_follower_steering_fsm #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [23:0] i_s_tdata,   // position[20:0], zero pad [23:21]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [39:0] o_m_tdata    // wheel_first[15:0], wheel_second[31:16],
                                     // steer_state[34:32], zero pad [39:35]
);
    import lfs_pkg::*;

    // Front end to queue.
    logic               front_vld;
    logic               front_rdy;
    t_entry             front_entry;

    // Queue to back end.
    logic               back_vld;
    logic               back_rdy;
    t_entry             back_entry;

    logic signed [15:0] wheel_first;
    logic signed [15:0] wheel_second;
    t_state             steer_state;

    // The pad bits of the input word are ignored.
    lfs_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (i_s_tvalid),
        .o_rdy   (o_s_tready),
        .i_pos   (signed'(i_s_tdata[20:0])),
        .o_vld   (front_vld),
        .i_rdy   (front_rdy),
        .o_entry (front_entry)
    );

    lfs_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push_vld  (front_vld),
        .o_push_rdy  (front_rdy),
        .i_push_data (front_entry),
        .o_pop_vld   (back_vld),
        .i_pop_rdy   (back_rdy),
        .o_pop_data  (back_entry)
    );

    lfs_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_vld    (back_vld),
        .o_rdy    (back_rdy),
        .i_entry  (back_entry),
        .o_vld    (o_m_tvalid),
        .i_rdy    (i_m_tready),
        .o_first  (wheel_first),
        .o_second (wheel_second),
        .o_state  (steer_state)
    );

    assign o_m_tdata = {5'b0, steer_state, wheel_second, wheel_first};

endmodule

// File: test/tb_top.sv
// Self-checking testbench for the line follower steering block. It streams
// sensor positions in, predicts each drive word and compares the results.
// Depends on lfs_pkg and line_follower_steering_fsm.
`timescale 1ns / 100ps

module tb_top;

    import lfs_pkg::*;

    // Cycles with no accepted word on either side before the run is declared hung.
    // The longest quiet stretch of a correct run is the long hold of the drive
    // side, so this leaves a wide margin.
    localparam int IDLE_LIMIT = 3000;

    // Length of the long hold of the drive side, and the number of drive words
    // after which it starts.
    localparam int HOLD_CYCLES = 300;
    localparam int HOLD_AFTER  = 400;

    localparam int RANDOM_ITEMS = 1750;

    // Next steering state, indexed by [current state][position bin].
    localparam t_state STEER_NEXT [8][6] = '{
        '{ST_CTR_RIGHT, ST_CTR_RIGHT, ST_CENTER,    ST_CTR_LEFT,  ST_CTR_LEFT, ST_LOST_CTR},
        '{ST_CTR_RIGHT, ST_CENTER,    ST_CENTER,    ST_CENTER,    ST_CTR_LEFT, ST_LOST_CTR},
        '{ST_RIGHT,     ST_CTR_RIGHT, ST_CENTER,    ST_CENTER,    ST_CTR_LEFT, ST_LOST_RGT},
        '{ST_CTR_RIGHT, ST_CENTER,    ST_CENTER,    ST_CTR_LEFT,  ST_LEFT,     ST_LOST_LFT},
        '{ST_RIGHT,     ST_CTR_RIGHT, ST_CTR_RIGHT, ST_CTR_RIGHT, ST_CENTER,   ST_LOST_RGT},
        '{ST_RIGHT,     ST_CTR_RIGHT, ST_CTR_RIGHT, ST_CTR_RIGHT, ST_CENTER,   ST_LOST_RGT},
        '{ST_CENTER,    ST_CTR_LEFT,  ST_CTR_LEFT,  ST_CTR_LEFT,  ST_LEFT,     ST_LOST_LFT},
        '{ST_CENTER,    ST_CTR_LEFT,  ST_CTR_LEFT,  ST_CTR_LEFT,  ST_LEFT,     ST_LOST_LFT}
    };

    // One predicted drive word.
    typedef struct packed {
        logic [15:0] wheel_first;
        logic [15:0] wheel_second;
        t_state      steer_state;
    } t_drive_word;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [23:0] i_s_tdata = '0;   // position[20:0], zero pad [23:21]
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [39:0] o_m_tdata;        // wheel_first[15:0], wheel_second[31:16],
                                   // steer_state[34:32], zero pad [39:35]

    // Positions waiting to be sent and drive words waiting to arrive.
    logic signed [20:0] pending_pos [$];
    t_drive_word        expected_drive [$];

    // Steering state as the predictor sees it after the last accepted sample.
    t_state steer_now = ST_CENTER;

    // Handshakes seen at the last rising edge, used by the falling-edge drivers.
    logic s_took = 1'b0;
    logic m_took = 1'b0;

    // Idle bookkeeping of both sides. In burst mode a side draws no idle gaps.
    int unsigned s_gap = 0;
    int unsigned m_gap = 0;
    bit          s_burst = 1'b0;
    bit          m_burst = 1'b0;

    int unsigned drive_count = 0;
    int unsigned hold_left = 0;
    bit          hold_done = 1'b0;
    int unsigned idle_cycles = 0;
    int unsigned error_count = 0;

    line_follower_steering_fsm i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Uniform integer in [lo, hi].
    function automatic int rand_between(input int lo, input int hi);
        return lo + int'($urandom_range(0, hi - lo));
    endfunction

    // Idle cycles before the next word on one side.
    function automatic int unsigned draw_gap(input bit burst);
        return burst ? 0 : $urandom_range(0, 15);
    endfunction

    // Random position. Most picks land inside one bin so that the state machine
    // walks through all of its states; the rest sit right at a threshold, take
    // the lost marker, fall above the far-right edge, or use the whole range.
    function automatic logic signed [20:0] pick_position();
        int pick;
        int edge_val;
        int val;
        pick = $urandom_range(0, 15);
        case (pick)
            0, 1: begin
                val = ($urandom_range(0, 1) != 0) ? rand_between(-1048576, -30001)
                                                  : rand_between(-30100, -30001);
            end
            2, 3:   val = rand_between(-30000, -15001);
            4, 5:   val = rand_between(-15000, 14999);
            6, 7:   val = rand_between(15000, 30000);
            8, 9:   val = rand_between(30001, 33400);
            10:     val = int'(POS_LOST);
            11:     val = rand_between(33401, 1048575);
            12:     val = int'($urandom_range(0, 21'h1FFFFF));
            default: begin
                case ($urandom_range(0, 5))
                    0:       edge_val = -30000;
                    1:       edge_val = -15000;
                    2:       edge_val = 15000;
                    3:       edge_val = 30000;
                    4:       edge_val = 33400;
                    default: edge_val = 1000000;
                endcase
                val = edge_val + rand_between(-2, 2);
            end
        endcase
        return 21'(val);
    endfunction

    // Works out the drive word that one accepted sample causes and advances the
    // predicted steering state.
    function automatic t_drive_word predict_drive(input logic signed [20:0] pos);
        int          pos_val;
        t_bin        pos_bin;
        t_state      next_state;
        int          first_val;
        int          second_val;
        t_drive_word word;
        pos_val = pos;
        // Any value above the far-right edge that is not the lost marker is
        // treated as a reading near the middle.
        if (pos_val < -30000)
            pos_bin = BIN_FAR_LEFT;
        else if (pos_val < -15000)
            pos_bin = BIN_LEFT;
        else if (pos_val < 15000)
            pos_bin = BIN_MID;
        else if (pos_val <= 30000)
            pos_bin = BIN_RIGHT;
        else if (pos_val <= 33400)
            pos_bin = BIN_FAR_RIGHT;
        else if (pos_val == 1000000)
            pos_bin = BIN_LOST;
        else
            pos_bin = BIN_MID;

        next_state = STEER_NEXT[steer_now][pos_bin];
        steer_now = next_state;

        case (next_state)
            ST_RIGHT: begin
                first_val = 10000;
                second_val = -2000;
            end
            ST_LOST_RGT: begin
                first_val = 8000;
                second_val = -6000;
            end
            ST_LEFT: begin
                first_val = -2000;
                second_val = 10000;
            end
            ST_LOST_LFT: begin
                first_val = -6000;
                second_val = 8000;
            end
            default: begin
                first_val = 8000;
                second_val = 8000;
            end
        endcase

        // Proportional corrections; integer division truncates toward zero and
        // the sums are exact in 32 bits before the 16-bit wrap below.
        if (next_state == ST_CTR_RIGHT)
            second_val = second_val + (pos_val - 15000) / 5;
        else if (next_state == ST_CTR_LEFT)
            first_val = first_val - (pos_val + 15000) / 5;

        word.wheel_first = first_val[15:0];
        word.wheel_second = second_val[15:0];
        word.steer_state = next_state;
        return word;
    endfunction

    // Sample side. A new word goes out once the previous one was taken and
    // the drawn gap has passed; with a zero gap tvalid simply stays high.
    always @(negedge i_clk) begin : drive_samples
        logic next_valid;
        next_valid = i_s_tvalid;
        if (!i_rst_n) begin
            next_valid = 1'b0;
        end else begin
            if (s_took)
                next_valid = 1'b0;
            if (!next_valid) begin
                if (s_gap != 0) begin
                    s_gap = s_gap - 1;
                end else if (pending_pos.size() != 0) begin
                    i_s_tdata <= {3'b000, pending_pos.pop_front()};
                    next_valid = 1'b1;
                    if ($urandom_range(0, 63) == 0)
                        s_burst = !s_burst;
                    s_gap = draw_gap(s_burst);
                end
            end
        end
        i_s_tvalid <= next_valid;
    end

    // Long hold of the drive side, counted here on its own. The sample side
    // keeps offering words meanwhile, so the pipeline fills and stalls.
    always @(negedge i_clk) begin : hold_drive
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (!hold_done && drive_count >= HOLD_AFTER) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
    end

    // Drive side ready. After each taken word it draws a gap during which
    // tready stays low; otherwise tready is high unless the long hold is on.
    always @(negedge i_clk) begin : drive_ready
        if (m_took) begin
            if ($urandom_range(0, 63) == 0)
                m_burst = !m_burst;
            m_gap = draw_gap(m_burst);
        end
        if (m_gap != 0) begin
            m_gap = m_gap - 1;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= (hold_left == 0);
        end
    end

    // Monitor. Every taken drive word is checked against the oldest
    // prediction, and every taken sample adds a prediction.
    always @(posedge i_clk) begin : check_drive
        t_drive_word want;
        s_took <= i_rst_n && i_s_tvalid && o_s_tready;
        m_took <= i_rst_n && o_m_tvalid && i_m_tready;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            drive_count <= drive_count + 1;
            if (expected_drive.size() == 0) begin
                $error("drive word with no sample pending: %h", o_m_tdata);
                error_count = error_count + 1;
            end else begin
                want = expected_drive.pop_front();
                if (o_m_tdata[15:0] !== want.wheel_first) begin
                    $error("wheel_first: expected %0d, actual %0d",
                           $signed(want.wheel_first), $signed(o_m_tdata[15:0]));
                    error_count = error_count + 1;
                end
                if (o_m_tdata[31:16] !== want.wheel_second) begin
                    $error("wheel_second: expected %0d, actual %0d",
                           $signed(want.wheel_second), $signed(o_m_tdata[31:16]));
                    error_count = error_count + 1;
                end
                if (o_m_tdata[34:32] !== want.steer_state) begin
                    $error("steer_state: expected %0d, actual %0d",
                           want.steer_state, o_m_tdata[34:32]);
                    error_count = error_count + 1;
                end
                if (o_m_tdata[39:35] !== 5'b00000) begin
                    $error("pad: expected %0d, actual %0d", 5'b00000, o_m_tdata[39:35]);
                    error_count = error_count + 1;
                end
            end
        end
        if (i_rst_n && i_s_tvalid && o_s_tready)
            expected_drive.push_back(predict_drive(i_s_tdata[20:0]));
    end

    // Watchdog on cycles where neither side moves a word.
    always @(posedge i_clk) begin : watchdog
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        // Directed opening: the range ends, every threshold from both sides,
        // the lost marker and its neighbors, readings above the far-right edge,
        // and a walk that visits all eight states, including both corrections, the
        // right one with a large offset that wraps at 16 bits.
        pending_pos.push_back(21'sd0);
        pending_pos.push_back(-21'sd1048576);   // center right, wrapped correction
        pending_pos.push_back(-21'sd1048576);   // right
        pending_pos.push_back(POS_LOST);        // lost right
        pending_pos.push_back(21'sd33400);      // back to center
        pending_pos.push_back(21'sd30000);      // center left
        pending_pos.push_back(21'sd30001);      // left
        pending_pos.push_back(POS_LOST);        // lost left
        pending_pos.push_back(-21'sd30001);     // center
        pending_pos.push_back(POS_LOST);        // lost center
        pending_pos.push_back(-21'sd15001);
        pending_pos.push_back(POS_LOST);
        pending_pos.push_back(-21'sd30000);
        pending_pos.push_back(21'sd15000);      // center left
        pending_pos.push_back(21'sd1048575);    // high reading counts as middle
        pending_pos.push_back(21'sd999999);
        pending_pos.push_back(21'sd1000001);
        pending_pos.push_back(-21'sd15000);
        pending_pos.push_back(21'sd14999);
        pending_pos.push_back(-21'sd30000);     // center right
        pending_pos.push_back(21'sd33401);
        pending_pos.push_back(-21'sd20000);
        pending_pos.push_back(-21'sd15001);
        pending_pos.push_back(21'sd33400);      // center left from center right
        pending_pos.push_back(-21'sd15001);
        repeat (RANDOM_ITEMS)
            pending_pos.push_back(pick_position());

        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Wait until every sample is taken and every drive word has arrived,
        // then let the clock run on to catch any stray words.
        while (pending_pos.size() != 0 || i_s_tvalid)
            @(posedge i_clk);
        while (expected_drive.size() != 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        if (error_count == 0 && expected_drive.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
